// ===== sv/ffkq_pkg.sv =====
// Shared types and constants for the first-fit keyed queue.
// Used by the channel interfaces, the storage cell, the top level and the checker.
// No dependencies.
package ffkq_pkg;

    localparam int KEY_BYTES = 19;
    localparam int KEY_W     = 8 * KEY_BYTES;
    localparam int SIZE_W    = 8;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_SHOW   = 2'd2,
        ACT_RSVD   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_DUP      = 3'd1,
        STAT_NONE_FIT = 3'd2,
        STAT_EMPTY    = 3'd3,
        STAT_FULL     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [63:0]       key0;
        logic [63:0]       key1;
        logic [23:0]       key2;
        logic [SIZE_W-1:0] size;
    } entry_t;

    typedef struct packed {
        status_t status;
        entry_t  ent;
        logic    last;
    } result_t;

    // Control that the top level hands to every cell in a cycle.
    typedef struct packed {
        logic load;
        logic shift;
        logic drop;
    } cell_ctrl_t;

endpackage

// ===== sv/ffkq_if.sv =====
// Request and response channel interfaces of the first-fit keyed queue.
// Depends on ffkq_pkg for the field widths.
interface ffkq_req_if
    import ffkq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [63:0]       key_part0;
    logic [63:0]       key_part1;
    logic [23:0]       key_part2;
    logic [SIZE_W-1:0] entry_size;
    logic [SIZE_W-1:0] limit_size;

    modport source (output valid, action, key_part0, key_part1, key_part2,
                    entry_size, limit_size, input ready);
    modport sink (input valid, action, key_part0, key_part1, key_part2,
                  entry_size, limit_size, output ready);
endinterface

interface ffkq_rsp_if
    import ffkq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic [63:0]       out_key0;
    logic [63:0]       out_key1;
    logic [23:0]       out_key2;
    logic [SIZE_W-1:0] out_size;
    logic              last;

    modport source (output valid, status, out_key0, out_key1, out_key2,
                    out_size, last, input ready);
    modport sink (input valid, status, out_key0, out_key1, out_key2,
                  out_size, last, output ready);
endinterface

// ===== sv/ffkq_cell.sv =====
// One storage cell of the queue chain: holds one entry and its valid bit.
// Depends on ffkq_pkg for entry_t and cell_ctrl_t.
module ffkq_cell
    import ffkq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  entry_t     nxt_ent,
    input  logic       nxt_valid,
    input  entry_t     head_ent,
    input  entry_t     load_ent,
    output entry_t     ent,
    output logic       valid,
    output logic       match
);

    entry_t ent_reg, ent_next;
    logic   valid_reg, valid_next;

    always_comb
    begin
        ent_next   = ent_reg;
        valid_next = valid_reg;
        if (ctrl.load)
        begin
            ent_next   = load_ent;
            valid_next = 1'b1;
        end
        else if (ctrl.shift)
        begin
            if (ctrl.drop)
            begin
                ent_next   = nxt_ent;
                valid_next = nxt_valid;
            end
            else if (valid_reg)
            begin
                // The last valid cell takes the head entry: the queue rotates.
                ent_next = nxt_valid ? nxt_ent : head_ent;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign ent   = ent_reg;
    assign valid = valid_reg;
    assign match = valid_reg && (ent_reg.key0 == load_ent.key0)
                   && (ent_reg.key1 == load_ent.key1)
                   && (ent_reg.key2 == load_ent.key2);

endmodule

// ===== sv/first_fit_keyed_queue.sv =====
// Insert, and remove or show on an empty queue: one transfer, result registered next cycle.
// Remove and show rotate the cell chain once, one entry per cycle;
// show waits at the head while a result is not taken.
// Throughput: one insert per cycle while results are taken; remove and show take no new request until their scan ends.
// Reset clears the valid bits, the entry count and the control; entry contents are kept.
// Top level of the first-fit keyed queue; depends on ffkq_pkg, ffkq_if, ffkq_cell.
module first_fit_keyed_queue
    import ffkq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int NAME_CHARS  = 20
)
(
    input  logic       clk,
    input  logic       rst_n,
    ffkq_req_if.sink   req,
    ffkq_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_len_reg, step_reg;
    action_t          op_reg;
    logic [SIZE_W-1:0] limit_reg;
    logic             pend_v_reg;
    entry_t           pend_reg;
    logic             out_v_reg;
    result_t          out_reg;

    entry_t     cell_ent   [QUEUE_DEPTH];
    logic       cell_valid [QUEUE_DEPTH];
    logic       cell_match [QUEUE_DEPTH];
    cell_ctrl_t cell_ctrl  [QUEUE_DEPTH];

    logic [KEY_W-1:0] raw_key, clean_key;
    entry_t  in_ent;
    action_t act;
    logic    accept, can_push, push, dup, full, ins_ok;
    logic    head_fit, step_en, drop, last_step;
    result_t push_res;

    // A name ends at its first zero character or after NAME_CHARS - 1 characters.
    always_comb
    begin
        logic ended;
        ended     = 1'b0;
        raw_key   = {req.key_part2, req.key_part1, req.key_part0};
        clean_key = '0;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            if (i >= NAME_CHARS - 1 || raw_key[8*i +: 8] == 8'd0)
            begin
                ended = 1'b1;
            end
            clean_key[8*i +: 8] = ended ? 8'd0 : raw_key[8*i +: 8];
        end
    end

    assign in_ent.key0 = clean_key[63:0];
    assign in_ent.key1 = clean_key[127:64];
    assign in_ent.key2 = clean_key[151:128];
    assign in_ent.size = req.entry_size;
    assign act         = action_t'(req.action);

    assign can_push  = !out_v_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && can_push;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        dup = 1'b0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            dup = dup | cell_match[i];
        end
    end

    assign full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign ins_ok = accept && (act == ACT_INSERT) && !dup && !full;

    assign head_fit  = cell_valid[0] && (cell_ent[0].size <= limit_reg);
    assign step_en   = (state_reg == ST_SCAN)
                       && !((op_reg == ACT_SHOW) && head_fit && pend_v_reg && !can_push);
    assign drop      = step_en && (op_reg == ACT_REMOVE) && head_fit && !pend_v_reg;
    assign last_step = (step_reg == scan_len_reg - CNT_W'(1));

    generate
        for (genvar g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            entry_t nxt_ent;
            logic   nxt_valid;
            logic   tail_sel;

            if (g == QUEUE_DEPTH - 1)
            begin : g_end
                assign nxt_ent   = '0;
                assign nxt_valid = 1'b0;
            end
            else
            begin : g_mid
                assign nxt_ent   = cell_ent[g+1];
                assign nxt_valid = cell_valid[g+1];
            end

            if (g == 0)
            begin : g_first
                assign tail_sel = !cell_valid[g];
            end
            else
            begin : g_rest
                assign tail_sel = !cell_valid[g] && cell_valid[g-1];
            end

            assign cell_ctrl[g].load  = ins_ok && tail_sel;
            assign cell_ctrl[g].shift = step_en;
            assign cell_ctrl[g].drop  = drop;

            ffkq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl[g]),
                .nxt_ent   (nxt_ent),
                .nxt_valid (nxt_valid),
                .head_ent  (cell_ent[0]),
                .load_ent  (in_ent),
                .ent       (cell_ent[g]),
                .valid     (cell_valid[g]),
                .match     (cell_match[g])
            );
        end
    endgenerate

    // Next state and the result pushed into the output register.
    always_comb
    begin
        state_next = state_reg;
        push       = 1'b0;
        push_res   = '{status: STAT_OK, ent: '0, last: 1'b1};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (act) inside
                        ACT_INSERT:
                        begin
                            push         = 1'b1;
                            push_res.ent = in_ent;
                            if (dup)
                            begin
                                push_res.status = STAT_DUP;
                            end
                            else if (full)
                            begin
                                push_res.status = STAT_FULL;
                            end
                        end
                        ACT_REMOVE, ACT_SHOW:
                        begin
                            if (count_reg == '0)
                            begin
                                push            = 1'b1;
                                push_res.status = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (step_en && (op_reg == ACT_SHOW) && head_fit && pend_v_reg)
                begin
                    push          = 1'b1;
                    push_res.ent  = pend_reg;
                    push_res.last = 1'b0;
                end
                if (step_en && last_step)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (can_push)
                begin
                    push = 1'b1;
                    if (pend_v_reg)
                    begin
                        push_res.ent = pend_reg;
                    end
                    else
                    begin
                        push_res.status = STAT_NONE_FIT;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (drop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (push)
            begin
                out_v_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_v_reg <= 1'b0;
            end
            if (accept)
            begin
                pend_v_reg <= 1'b0;
                step_reg   <= '0;
            end
            else if (step_en)
            begin
                step_reg <= step_reg + CNT_W'(1);
                if (head_fit && ((op_reg == ACT_SHOW) || !pend_v_reg))
                begin
                    pend_v_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_reg <= push_res;
        end
        if (accept)
        begin
            op_reg       <= act;
            limit_reg    <= req.limit_size;
            scan_len_reg <= count_reg;
        end
        if (step_en && head_fit && ((op_reg == ACT_SHOW) || !pend_v_reg))
        begin
            pend_reg <= cell_ent[0];
        end
    end

    assign rsp.valid    = out_v_reg;
    assign rsp.status   = out_reg.status;
    assign rsp.out_key0 = out_reg.ent.key0;
    assign rsp.out_key1 = out_reg.ent.key1;
    assign rsp.out_key2 = out_reg.ent.key2;
    assign rsp.out_size = out_reg.ent.size;
    assign rsp.last     = out_reg.last;

endmodule

// ===== sv/ffkq_checker.sv =====
// Port-level checks for the first-fit keyed queue, bound to the top level.
// Depends on ffkq_pkg and first_fit_keyed_queue.
module ffkq_checker
    import ffkq_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic [1:0]        req_action,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [2:0]        rsp_status,
    input logic [63:0]       rsp_key0,
    input logic [63:0]       rsp_key1,
    input logic [23:0]       rsp_key2,
    input logic [SIZE_W-1:0] rsp_size,
    input logic              rsp_last
);

    // Any status other than ok ends the results of an item.
    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != STAT_OK) |-> rsp_last)
        else $error("error status without last");

    // Empty and none-fit results carry no entry.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((rsp_status == STAT_EMPTY) || (rsp_status == STAT_NONE_FIT))
        |-> (rsp_key0 == '0) && (rsp_key1 == '0) && (rsp_key2 == '0) && (rsp_size == '0))
        else $error("empty or none-fit result carries data");

    // An insert transfer answers in the next cycle with a single result.
    a_insert_answer: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_action == ACT_INSERT) |=> rsp_valid && rsp_last)
        else $error("insert result missing");

    // A result that is not taken stays.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_last))
        else $error("response dropped before transfer");

endmodule

bind first_fit_keyed_queue ffkq_checker u_ffkq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_action (req.action),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_key0   (rsp.out_key0),
    .rsp_key1   (rsp.out_key1),
    .rsp_key2   (rsp.out_key2),
    .rsp_size   (rsp.out_size),
    .rsp_last   (rsp.last)
);
